### src/disk_grid_free_test_and_insert_core_assert.svh
// Assertion macros for the disk grid free test and insert core.
// Depends on nothing; included by the core.
`ifndef DISK_GRID_FREE_TEST_AND_INSERT_CORE_ASSERT_SVH
`define DISK_GRID_FREE_TEST_AND_INSERT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DGF_ASSERT_AT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
`define DGF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DGF_ASSERT_AT(lbl, clk, rstn, expr)
`define DGF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/dgfti_pkg.sv
// Package for the disk grid free test and insert core.
// Holds codes, default sizes, the state type and the clamp helper; no dependencies.
package dgfti_pkg;

    localparam int MAX_GRID_SIDE_DEF = 64;
    localparam int MAX_DISKS_DEF     = 4096;
    localparam int SIDE_W            = 9;
    localparam int DIV_STEPS         = 17;

    localparam logic [1:0] MODE_CHECK  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] CFG_GRID_CELLS = 2'd0;
    localparam logic [1:0] CFG_CELL_SIZE  = 2'd1;
    localparam logic [1:0] CFG_MIN_RADIUS = 2'd2;

    localparam logic [6:0]  GRID_CELLS_RST = 7'd64;
    localparam logic [16:0] CELL_SIZE_RST  = 17'd1024;
    localparam logic [15:0] MIN_RADIUS_RST = 16'd724;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_WIN,
        S_C_RD, S_C_OWN, S_C_DSK, S_C_SQ, S_C_CMP,
        S_I_MUL, S_I_DIF, S_I_SQ, S_I_CMP, S_I_OWN,
        S_DONE
    } t_state;

    function automatic logic [SIDE_W-1:0] clamp_idx(input logic signed [19:0] v,
                                                     input logic [SIDE_W-1:0] side);
        logic signed [19:0] top;
        top = $signed({11'b0, side - 9'd1});
        if (v < 0) begin
            clamp_idx = '0;
        end else if (v > top) begin
            clamp_idx = side - 9'd1;
        end else begin
            clamp_idx = v[SIDE_W-1:0];
        end
    endfunction

endpackage

### src/disk_grid_free_test_and_insert_core.sv
// Disk grid free test and insert core: grid memory, disk store, window scan.
// Depends on dgfti_pkg and disk_grid_free_test_and_insert_core_assert.svh.
//
// channel   | direction | handshake                   | payload
// request   | in        | start & !busy               | i_mode i_pos_x i_pos_y i_radius
// result    | out       | o_done, one cycle           | o_is_free o_point_index o_status
// config    | in        | i_cfg_valid & o_cfg_ready   | i_cfg_index i_cfg_data
//
// Check: a serial divider of DIV_STEPS steps sizes the window, then an owner memory
// read per window cell and a disk store read, square and compare per referenced disk.
// Insert: the divider, then multiply, difference, square and compare per window cell.
// Clear and reset: one pass over MAX_GRID_SIDE*MAX_GRID_SIDE cells (4096 by default).
// Outside, full and unused requests go straight to done without a scan.
// Reset is synchronous; busy stays high during the clearing pass; o_done is never held.
`include "disk_grid_free_test_and_insert_core_assert.svh"
module disk_grid_free_test_and_insert_core #(
    parameter int MAX_GRID_SIDE = dgfti_pkg::MAX_GRID_SIDE_DEF,
    parameter int MAX_DISKS     = dgfti_pkg::MAX_DISKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [17:0] i_pos_x,
    input  logic signed [17:0] i_pos_y,
    input  logic [14:0]        i_radius,
    output logic               o_done,
    output logic               o_is_free,
    output logic [11:0]        o_point_index,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    localparam int CW    = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
    localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int NW    = $clog2(MAX_DISKS + 1);
    localparam int SW    = dgfti_pkg::SIDE_W;
    localparam int OW    = DW + 1;

    dgfti_pkg::t_state r_state, n_state;

    logic [6:0]  r_grid;
    logic [16:0] r_cs;
    logic [15:0] r_minr;

    logic [1:0]         r_mode;
    logic signed [17:0] r_x, r_y;
    logic [14:0]        r_r;
    logic signed [11:0] r_cx, r_cy;
    logic [16:0]        r_span;
    logic [33:0]        r_lim;
    logic [17:0]        r_rem;
    logic [16:0]        r_dnum, r_q;
    logic [4:0]         r_dcnt;
    logic [CW-1:0]      r_x1, r_y0, r_y1, r_gx, r_gy, r_ocx, r_ocy;
    logic [NW-1:0]      r_count;
    logic [DW-1:0]      r_idx;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clr_ack;
    logic               r_free;
    logic [11:0]        r_pidx;
    logic [1:0]         r_stat;
    logic [16:0]        r_ax, r_ay;
    logic [15:0]        r_rs;
    logic               r_far;
    logic [33:0]        r_sx, r_sy;
    logic [31:0]        r_rr;
    logic [25:0]        r_lx, r_ly;

    logic [OW-1:0] own_mem [DEPTH];
    logic [46:0]   dsk_mem [MAX_DISKS];
    logic [OW-1:0] r_own_q;
    logic [46:0]   r_dsk_q;

    logic [SW-1:0]      w_side;
    logic [16:0]        w_cs;
    logic signed [27:0] w_px, w_py;
    logic               w_acc, w_outside, w_full;
    logic [17:0]        w_trial;
    logic signed [19:0] w_cxe, w_cye, w_q, w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic               w_last, w_adv, w_overlap, w_mark;
    logic [AW-1:0]      w_cell_addr, w_own_addr;
    logic               w_own_we;
    logic [AW-1:0]      w_own_waddr;
    logic [OW-1:0]      w_own_wdata;
    logic [18:0]        w_dx, w_dy, w_adx, w_ady;
    logic signed [26:0] w_xe, w_ye, w_dxl, w_dxh, w_dyl, w_dyh;
    logic [26:0]        w_axl, w_axh, w_ayl, w_ayh, w_mx, w_my;
    logic [34:0]        w_sum;
    logic               w_scan;

    assign w_side = (r_grid == 7'd0) ? SW'(1) :
                    ((SW'(r_grid) > SW'(MAX_GRID_SIDE)) ? SW'(MAX_GRID_SIDE) : SW'(r_grid));
    assign w_cs   = (r_cs == 17'd0) ? 17'd1 : ((r_cs > 17'd65536) ? 17'd65536 : r_cs);

    assign w_acc     = start && !busy;
    assign w_outside = i_pos_x[17] || i_pos_x[16] || i_pos_y[17] || i_pos_y[16];
    assign w_full    = (r_count >= NW'(MAX_DISKS));
    assign w_px      = i_pos_x * $signed({1'b0, w_side});
    assign w_py      = i_pos_y * $signed({1'b0, w_side});

    assign w_trial = {r_rem[16:0], r_dnum[16]};

    assign w_cxe  = {{8{r_cx[11]}}, r_cx};
    assign w_cye  = {{8{r_cy[11]}}, r_cy};
    assign w_q    = $signed({3'b0, r_q});
    assign w_lo_x = w_cxe - w_q - ((r_mode == dgfti_pkg::MODE_CHECK) ? 20'sd1 : 20'sd0);
    assign w_hi_x = w_cxe + w_q + 20'sd1;
    assign w_lo_y = w_cye - w_q - ((r_mode == dgfti_pkg::MODE_CHECK) ? 20'sd1 : 20'sd0);
    assign w_hi_y = w_cye + w_q + 20'sd1;

    assign w_last      = (r_gx == r_x1) && (r_gy == r_y1);
    assign w_cell_addr = AW'(r_gy) * AW'(MAX_GRID_SIDE) + AW'(r_gx);
    assign w_own_addr  = AW'(r_ocy) * AW'(MAX_GRID_SIDE) + AW'(r_ocx);

    assign w_dx  = {r_x[17], r_x} - {3'b0, r_dsk_q[46:31]};
    assign w_dy  = {r_y[17], r_y} - {3'b0, r_dsk_q[30:15]};
    assign w_adx = w_dx[18] ? (19'd0 - w_dx) : w_dx;
    assign w_ady = w_dy[18] ? (19'd0 - w_dy) : w_dy;

    assign w_sum     = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_overlap = !({3'b0, r_rr} < w_sum);
    assign w_mark    = !r_far && (w_sum < {1'b0, r_lim});

    assign w_xe  = {{9{r_x[17]}}, r_x};
    assign w_ye  = {{9{r_y[17]}}, r_y};
    assign w_dxl = w_xe - $signed({1'b0, r_lx});
    assign w_dxh = w_xe - $signed({1'b0, r_lx}) - $signed({10'b0, w_cs});
    assign w_dyl = w_ye - $signed({1'b0, r_ly});
    assign w_dyh = w_ye - $signed({1'b0, r_ly}) - $signed({10'b0, w_cs});
    assign w_axl = w_dxl[26] ? (27'd0 - w_dxl) : w_dxl;
    assign w_axh = w_dxh[26] ? (27'd0 - w_dxh) : w_dxh;
    assign w_ayl = w_dyl[26] ? (27'd0 - w_dyl) : w_dyl;
    assign w_ayh = w_dyh[26] ? (27'd0 - w_dyh) : w_dyh;
    assign w_mx  = (w_axl > w_axh) ? w_axl : w_axh;
    assign w_my  = (w_ayl > w_ayh) ? w_ayl : w_ayh;

    assign w_scan = (r_state == dgfti_pkg::S_C_RD) || (r_state == dgfti_pkg::S_I_MUL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dgfti_pkg::S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = r_clr_ack ? dgfti_pkg::S_DONE : dgfti_pkg::S_IDLE;
                end
            end
            dgfti_pkg::S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        dgfti_pkg::MODE_CHECK: n_state = dgfti_pkg::S_DIV;
                        dgfti_pkg::MODE_INSERT: begin
                            n_state = (w_outside || w_full) ? dgfti_pkg::S_DONE
                                                            : dgfti_pkg::S_DIV;
                        end
                        dgfti_pkg::MODE_CLEAR: n_state = dgfti_pkg::S_CLEAR;
                        default: n_state = dgfti_pkg::S_DONE;
                    endcase
                end
            end
            dgfti_pkg::S_DIV: begin
                if (r_dcnt == 5'(dgfti_pkg::DIV_STEPS - 1)) n_state = dgfti_pkg::S_WIN;
            end
            dgfti_pkg::S_WIN: begin
                n_state = (r_mode == dgfti_pkg::MODE_CHECK) ? dgfti_pkg::S_C_RD
                                                            : dgfti_pkg::S_I_MUL;
            end
            dgfti_pkg::S_C_RD: n_state = dgfti_pkg::S_C_OWN;
            dgfti_pkg::S_C_OWN: begin
                if (r_own_q[OW-1]) n_state = dgfti_pkg::S_C_DSK;
                else if (w_last) n_state = dgfti_pkg::S_DONE;
                else n_state = dgfti_pkg::S_C_RD;
            end
            dgfti_pkg::S_C_DSK: n_state = dgfti_pkg::S_C_SQ;
            dgfti_pkg::S_C_SQ:  n_state = dgfti_pkg::S_C_CMP;
            dgfti_pkg::S_C_CMP: begin
                if (w_overlap || w_last) n_state = dgfti_pkg::S_DONE;
                else n_state = dgfti_pkg::S_C_RD;
            end
            dgfti_pkg::S_I_MUL: n_state = dgfti_pkg::S_I_DIF;
            dgfti_pkg::S_I_DIF: n_state = dgfti_pkg::S_I_SQ;
            dgfti_pkg::S_I_SQ:  n_state = dgfti_pkg::S_I_CMP;
            dgfti_pkg::S_I_CMP: n_state = w_last ? dgfti_pkg::S_I_OWN : dgfti_pkg::S_I_MUL;
            dgfti_pkg::S_I_OWN: n_state = dgfti_pkg::S_DONE;
            dgfti_pkg::S_DONE:  n_state = dgfti_pkg::S_IDLE;
            default: n_state = dgfti_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_own_we    = 1'b0;
        w_own_waddr = w_cell_addr;
        w_own_wdata = {1'b1, r_idx};
        w_adv       = 1'b0;
        case (r_state)
            dgfti_pkg::S_CLEAR: begin
                w_own_we    = 1'b1;
                w_own_waddr = r_clr_addr;
                w_own_wdata = '0;
            end
            dgfti_pkg::S_C_OWN: w_adv = !r_own_q[OW-1];
            dgfti_pkg::S_C_CMP: w_adv = !w_overlap;
            dgfti_pkg::S_I_CMP: begin
                w_own_we = w_mark;
                w_adv    = 1'b1;
            end
            dgfti_pkg::S_I_OWN: begin
                w_own_we    = 1'b1;
                w_own_waddr = w_own_addr;
            end
            default: begin
                w_own_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_own_we) own_mem[w_own_waddr] <= w_own_wdata;
        r_own_q <= own_mem[w_cell_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_mode == dgfti_pkg::MODE_INSERT && !w_outside && !w_full) begin
            dsk_mem[r_count[DW-1:0]] <= {i_pos_x[15:0], i_pos_y[15:0], i_radius};
        end
        r_dsk_q <= dsk_mem[r_own_q[DW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dgfti_pkg::S_CLEAR;
            r_grid     <= dgfti_pkg::GRID_CELLS_RST;
            r_cs       <= dgfti_pkg::CELL_SIZE_RST;
            r_minr     <= dgfti_pkg::MIN_RADIUS_RST;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_clr_ack  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dgfti_pkg::CFG_GRID_CELLS: r_grid <= i_cfg_data[6:0];
                    dgfti_pkg::CFG_CELL_SIZE:  r_cs   <= i_cfg_data;
                    dgfti_pkg::CFG_MIN_RADIUS: r_minr <= i_cfg_data[15:0];
                    default: r_grid <= r_grid;
                endcase
            end
            if (r_state == dgfti_pkg::S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (w_acc) begin
                r_clr_ack <= 1'b1;
                if (i_mode == dgfti_pkg::MODE_CLEAR) begin
                    r_count    <= '0;
                    r_clr_addr <= '0;
                end else if (i_mode == dgfti_pkg::MODE_INSERT && !w_outside && !w_full) begin
                    r_count <= r_count + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_mode;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_r    <= i_radius;
            r_cx   <= w_px[27:16];
            r_cy   <= w_py[27:16];
            r_span <= 17'({2'b0, i_radius} + {1'b0, r_minr});
            r_rem  <= '0;
            r_q    <= '0;
            r_dcnt <= '0;
            r_idx  <= r_count[DW-1:0];
            r_free <= 1'b0;
            r_pidx <= 12'd0;
            r_stat <= dgfti_pkg::ST_OK;
            if (i_mode == dgfti_pkg::MODE_CHECK) begin
                r_dnum <= 17'({3'b0, i_radius} + {1'b0, w_cs} - 18'd1);
            end else begin
                r_dnum <= 17'({2'b0, i_radius} + {1'b0, r_minr});
            end
            if (i_mode == dgfti_pkg::MODE_INSERT) begin
                if (w_outside) r_stat <= dgfti_pkg::ST_OUTSIDE;
                else if (w_full) r_stat <= dgfti_pkg::ST_FULL;
                else r_pidx <= 12'(r_count[DW-1:0]);
            end
        end
        case (r_state)
            dgfti_pkg::S_DIV: begin
                r_dcnt <= r_dcnt + 5'd1;
                r_dnum <= {r_dnum[15:0], 1'b0};
                if (w_trial >= {1'b0, w_cs}) begin
                    r_rem <= w_trial - {1'b0, w_cs};
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[15:0], 1'b0};
                end
            end
            dgfti_pkg::S_WIN: begin
                r_x1  <= CW'(dgfti_pkg::clamp_idx(w_hi_x, w_side));
                r_y0  <= CW'(dgfti_pkg::clamp_idx(w_lo_y, w_side));
                r_y1  <= CW'(dgfti_pkg::clamp_idx(w_hi_y, w_side));
                r_gx  <= CW'(dgfti_pkg::clamp_idx(w_lo_x, w_side));
                r_gy  <= CW'(dgfti_pkg::clamp_idx(w_lo_y, w_side));
                r_ocx <= CW'(dgfti_pkg::clamp_idx(w_cxe, w_side));
                r_ocy <= CW'(dgfti_pkg::clamp_idx(w_cye, w_side));
                r_lim <= r_span * r_span;
                r_free <= (r_mode == dgfti_pkg::MODE_CHECK);
            end
            dgfti_pkg::S_C_DSK: begin
                r_ax <= w_adx[16:0];
                r_ay <= w_ady[16:0];
                r_rs <= {1'b0, r_r} + {1'b0, r_dsk_q[14:0]};
            end
            dgfti_pkg::S_C_SQ, dgfti_pkg::S_I_SQ: begin
                r_sx <= r_ax * r_ax;
                r_sy <= r_ay * r_ay;
                r_rr <= r_rs * r_rs;
            end
            dgfti_pkg::S_C_CMP: begin
                if (w_overlap) r_free <= 1'b0;
            end
            dgfti_pkg::S_I_MUL: begin
                r_lx <= 26'(r_gx) * 26'(w_cs);
                r_ly <= 26'(r_gy) * 26'(w_cs);
            end
            dgfti_pkg::S_I_DIF: begin
                r_ax  <= w_mx[16:0];
                r_ay  <= w_my[16:0];
                r_far <= (w_mx[26:17] != 10'd0) || (w_my[26:17] != 10'd0);
            end
            default: begin
                r_far <= r_far;
            end
        endcase
        if (w_adv && !w_last) begin
            if (r_gy == r_y1) begin
                r_gy <= r_y0;
                r_gx <= r_gx + CW'(1);
            end else begin
                r_gy <= r_gy + CW'(1);
            end
        end
    end

    assign busy          = (r_state != dgfti_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = (r_state == dgfti_pkg::S_DONE);
    assign o_is_free     = r_free;
    assign o_point_index = r_pidx;
    assign o_status      = r_stat;

    `DGF_ASSERT_NEXT(a_done_one_cycle, i_clk, i_rst_n, o_done, !o_done)
    `DGF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `DGF_ASSERT_AT(a_count_bound, i_clk, i_rst_n, r_count <= NW'(MAX_DISKS))
    `DGF_ASSERT_AT(a_scan_in_window, i_clk, i_rst_n, !w_scan || (r_gx <= r_x1 && r_gy <= r_y1))
    `DGF_ASSERT_AT(a_reject_no_index, i_clk, i_rst_n, !(o_done && o_status != dgfti_pkg::ST_OK) || (o_point_index == 12'd0))

endmodule

### dv/tb_top.sv
// Testbench for disk_grid_free_test_and_insert_core: checks, inserts and clears
// against a behavioral model of the grid and disk store; depends on dgfti_pkg.
`timescale 1ns / 100ps
module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         GRID_MEM    = 4096;

    typedef struct {
        logic        is_free;
        logic [11:0] point_index;
        logic [1:0]  status;
    } answer_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_mode;
    logic signed [17:0] i_pos_x;
    logic signed [17:0] i_pos_y;
    logic [14:0]        i_radius;
    logic               o_done;
    logic               o_is_free;
    logic [11:0]        o_point_index;
    logic [1:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [16:0]        i_cfg_data;

    disk_grid_free_test_and_insert_core u_dut (.*);

    logic [12:0]   cell_owner_m[GRID_MEM];
    longint        disk_x_m[GRID_MEM];
    longint        disk_y_m[GRID_MEM];
    longint        disk_r_m[GRID_MEM];
    int            disk_count_m;
    longint        grid_cells_m;
    longint        cell_size_m;
    longint        min_radius_m;
    answer_t       pending_answers[$];
    int            mismatches;
    int            requests_sent;
    int            answers_seen;
    int            inserts_done;
    int            free_hits;
    int            sender_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic longint side_m();
        if (grid_cells_m == 0) return 1;
        if (grid_cells_m > 64) return 64;
        return grid_cells_m;
    endfunction

    function automatic longint edge_m();
        if (cell_size_m == 0) return 1;
        if (cell_size_m > 65536) return 65536;
        return cell_size_m;
    endfunction

    function automatic longint clamp_m(longint v, longint hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic longint sq_dist_m(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic answer_t grid_model_step(logic [1:0] m, longint x, longint y,
                                                longint r);
        answer_t a;
        longint g, cs, cx, cy, reach, x0, x1, y0, y1, span, lim, lx, ly, rs;
        a = '{1'b0, 12'd0, dgfti_pkg::ST_OK};
        g = side_m();
        cs = edge_m();
        cx = (x * g) >>> 16;
        cy = (y * g) >>> 16;
        if (m == dgfti_pkg::MODE_CHECK) begin
            reach = (r + cs - 1) / cs + 1;
            x0 = clamp_m(cx - reach, g - 1); x1 = clamp_m(cx + reach, g - 1);
            y0 = clamp_m(cy - reach, g - 1); y1 = clamp_m(cy + reach, g - 1);
            a.is_free = 1'b1;
            for (longint gx = x0; gx <= x1; gx++)
                for (longint gy = y0; gy <= y1; gy++) begin
                    if (cell_owner_m[gy * 64 + gx][12]) begin
                        int k;
                        k = cell_owner_m[gy * 64 + gx][11:0];
                        rs = r + disk_r_m[k];
                        if (!(rs * rs < sq_dist_m(x, y, disk_x_m[k], disk_y_m[k])))
                            a.is_free = 1'b0;
                    end
                end
        end else if (m == dgfti_pkg::MODE_INSERT) begin
            if (x < 0 || x > 65535 || y < 0 || y > 65535) begin
                a.status = dgfti_pkg::ST_OUTSIDE;
            end else if (disk_count_m >= GRID_MEM) begin
                a.status = dgfti_pkg::ST_FULL;
            end else begin
                span = r + min_radius_m;
                lim = span * span;
                reach = span / cs;
                x0 = clamp_m(cx - reach, g - 1); x1 = clamp_m(cx + reach + 1, g - 1);
                y0 = clamp_m(cy - reach, g - 1); y1 = clamp_m(cy + reach + 1, g - 1);
                for (longint gx = x0; gx <= x1; gx++)
                    for (longint gy = y0; gy <= y1; gy++) begin
                        lx = gx * cs;
                        ly = gy * cs;
                        if (sq_dist_m(x, y, lx, ly) < lim && sq_dist_m(x, y, lx + cs, ly) < lim
                            && sq_dist_m(x, y, lx, ly + cs) < lim
                            && sq_dist_m(x, y, lx + cs, ly + cs) < lim)
                            cell_owner_m[gy * 64 + gx] = {1'b1, 12'(disk_count_m)};
                    end
                cell_owner_m[clamp_m(cy, g - 1) * 64 + clamp_m(cx, g - 1)] =
                    {1'b1, 12'(disk_count_m)};
                disk_x_m[disk_count_m] = x;
                disk_y_m[disk_count_m] = y;
                disk_r_m[disk_count_m] = r;
                a.point_index = 12'(disk_count_m);
                disk_count_m++;
                inserts_done++;
            end
        end else if (m == dgfti_pkg::MODE_CLEAR) begin
            foreach (cell_owner_m[i]) cell_owner_m[i] = '0;
            disk_count_m = 0;
        end
        return a;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            answer_t want;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                answers_seen++;
                if (o_is_free) free_hits++;
                if (o_is_free !== want.is_free)
                    report_mismatch("is_free", o_is_free, want.is_free);
                if (o_point_index !== want.point_index)
                    report_mismatch("point_index", o_point_index, want.point_index);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    task automatic send_request(logic [1:0] m, logic signed [17:0] x, logic signed [17:0] y,
                                logic [14:0] r);
        int gap;
        answer_t expect_ans;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_mode <= m;
        i_pos_x <= x;
        i_pos_y <= y;
        i_radius <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expect_ans = grid_model_step(m, longint'(x), longint'(y), longint'(r));
        pending_answers = {pending_answers, expect_ans};
        requests_sent++;
    endtask

    task automatic drain_answers();
        @(negedge i_clk) start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [16:0] value);
        drain_answers();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == dgfti_pkg::CFG_GRID_CELLS) grid_cells_m = value & 17'h7F;
        else if (idx == dgfti_pkg::CFG_CELL_SIZE) cell_size_m = value;
        else if (idx == dgfti_pkg::CFG_MIN_RADIUS) min_radius_m = value & 17'hFFFF;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(logic [16:0] g, logic [16:0] cs, logic [16:0] mr);
        write_register(dgfti_pkg::CFG_GRID_CELLS, g);
        write_register(dgfti_pkg::CFG_CELL_SIZE, cs);
        write_register(dgfti_pkg::CFG_MIN_RADIUS, mr);
    endtask

    function automatic logic signed [17:0] pick_coord();
        if ($urandom_range(99) < 88) return 18'($urandom_range(65535));
        return 18'($signed(32'($urandom_range(196607)) - 32'sd65536));
    endfunction

    function automatic logic [14:0] pick_radius();
        if ($urandom_range(99) < 85) return 15'($urandom_range(2047));
        return 15'($urandom_range(16384));
    endfunction

    task automatic send_random(int n, int clear_pct);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < clear_pct)
                send_request(dgfti_pkg::MODE_CLEAR, pick_coord(), pick_coord(), 15'd0);
            else if (p < clear_pct + 2)
                send_request(MODE_UNUSED, pick_coord(), pick_coord(), 15'($urandom));
            else if (p < 55)
                send_request(dgfti_pkg::MODE_CHECK, pick_coord(), pick_coord(), pick_radius());
            else
                send_request(dgfti_pkg::MODE_INSERT, pick_coord(), pick_coord(), pick_radius());
        end
    endtask

    task automatic test_directed();
        send_request(dgfti_pkg::MODE_CHECK, 18'sd32768, 18'sd32768, 15'd16384);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd0, 18'sd0, 15'd0);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd65535, 18'sd65535, 15'd16384);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd32768, 18'sd32768, 15'd2000);
        send_request(dgfti_pkg::MODE_INSERT, -18'sd1, 18'sd100, 15'd10);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd100, 18'sd65536, 15'd10);
        send_request(dgfti_pkg::MODE_INSERT, -18'sd65536, 18'sd131071, 15'd10);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd131071, -18'sd65536, 15'd10);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd32768, 18'sd34768, 15'd0);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd32768, 18'sd34769, 15'd0);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd32768, 18'sd30000, 15'd100);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd5000, 18'sd5000, 15'd0);
        send_request(dgfti_pkg::MODE_CHECK, -18'sd65536, -18'sd65536, 15'd16384);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd131071, 18'sd131071, 15'd16384);
        send_request(dgfti_pkg::MODE_CHECK, -18'sd10, 18'sd10, 15'd20);
        send_request(MODE_UNUSED, 18'sd131071, -18'sd1, 15'h7FFF);
        send_request(dgfti_pkg::MODE_CLEAR, 18'sd0, 18'sd0, 15'd0);
        send_request(dgfti_pkg::MODE_CHECK, 18'sd32768, 18'sd32768, 15'd16384);
        send_request(dgfti_pkg::MODE_INSERT, 18'sd65535, 18'sd0, 15'd16384);
    endtask

    task automatic test_config_sweep();
        set_geometry(17'd0, 17'd0, 17'd0);
        send_random(25, 0);
        set_geometry(17'd127, 17'h1FFFF, 17'd65535);
        send_random(25, 0);
        set_geometry(17'd64, 17'd1, 17'd1);
        send_random(10, 0);
        set_geometry(17'd16, 17'd4096, 17'd2896);
        send_random(50, 0);
        set_geometry(17'd1, 17'd65536, 17'd40000);
        send_random(30, 0);
        set_geometry(17'd32, 17'd2048, 17'd1448);
        send_random(50, 0);
    endtask

    task automatic test_random_traffic();
        set_geometry(17'd64, 17'd1024, 17'd724);
        send_request(dgfti_pkg::MODE_CLEAR, 18'sd0, 18'sd0, 15'd0);
        sender_idle_pct = 18;
        send_random(550, 1);
        sender_idle_pct = 70;
        send_random(550, 1);
        sender_idle_pct = 0;
        send_random(550, 1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = dgfti_pkg::MODE_CHECK;
        i_pos_x = '0;
        i_pos_y = '0;
        i_radius = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = dgfti_pkg::CFG_GRID_CELLS;
        i_cfg_data = '0;
        mismatches = 0;
        requests_sent = 0;
        answers_seen = 0;
        inserts_done = 0;
        free_hits = 0;
        sender_idle_pct = 0;
        foreach (cell_owner_m[i]) begin
            cell_owner_m[i] = '0;
            disk_x_m[i] = 0;
            disk_y_m[i] = 0;
            disk_r_m[i] = 0;
        end
        disk_count_m = 0;
        grid_cells_m = dgfti_pkg::GRID_CELLS_RST;
        cell_size_m = dgfti_pkg::CELL_SIZE_RST;
        min_radius_m = dgfti_pkg::MIN_RADIUS_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_random_traffic();
        drain_answers();
        repeat (50) @(posedge i_clk);

        $display("requests %0d, results %0d, disks stored %0d, free answers %0d",
                 requests_sent, answers_seen, inserts_done, free_hits);
        $display("covered extreme grid settings, outside inserts, unused mode, clears");
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
